/* design/ptd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared widths, codes and controller/datapath bundles for the periodic tick
// dispatcher.
// ----------------------------------------------------------------------------
package ptd_pkg;

  localparam int DEF_NUM_CHANNELS = 16;
  localparam int SCAN_LIMIT       = 16;

  localparam int CMD_W  = 2;
  localparam int CH_W   = 4;
  localparam int PER_W  = 16;
  localparam int TICK_W = 32;
  localparam int ACT_W  = 5;

  localparam logic [ACT_W-1:0] ACT_RESET = 5'd16;

  localparam logic KIND_FIRE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK = 2'd0,
    CMD_SET  = 2'd1,
    CMD_READ = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    OUT_READ,
    OUT_FIRE_MID,
    OUT_FIRE_LAST
  } out_src_t;

  typedef struct packed {
    logic     capture;
    logic     store_tick;
    logic     tbl_rd;
    logic     rd_scan;
    logic     tbl_wr;
    logic     wr_zero;
    logic     div_start;
    logic     div_scan;
    logic     scan_clr;
    logic     scan_inc;
    logic     pend_load;
    logic     pend_clr;
    logic     out_load;
    out_src_t out_src;
  } ptd_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic chan_ok;
    logic per_zero;
    logic tbl_per_zero;
    logic div_done;
    logic rem_zero;
    logic scan_last;
    logic scan_empty;
    logic out_free;
    logic pend_valid;
  } ptd_sts_t;

endpackage
`default_nettype wire

/* design/ptd_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptd_if
// Request, response and configuration channels of the tick dispatcher.
// ----------------------------------------------------------------------------
interface ptd_req_if import ptd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [CH_W-1:0]   channel;
  logic [PER_W-1:0]  period;
  logic [TICK_W-1:0] tick_value;

  modport source (output valid, command, channel, period, tick_value, input ready);
  modport sink   (input valid, command, channel, period, tick_value, output ready);
endinterface

interface ptd_rsp_if import ptd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [CH_W-1:0]   out_channel;
  logic [PER_W-1:0]  out_period;
  logic [TICK_W-1:0] current_tick;
  logic              last;

  modport source (output valid, kind, out_channel, out_period, current_tick, last,
                  input ready);
  modport sink   (input valid, kind, out_channel, out_period, current_tick, last,
                  output ready);
endinterface

interface ptd_cfg_if import ptd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] active_channels;

  modport source (output valid, active_channels, input ready);
  modport sink   (input valid, active_channels, output ready);
endinterface
`default_nettype wire

/* design/ptd_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptd_div
// Serial restoring remainder unit: 32-bit dividend by 16-bit divisor,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ptd_div import ptd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [TICK_W-1:0] dividend,
  input  logic [PER_W-1:0]  divisor,
  output logic              done,
  output logic [PER_W-1:0]  rem
);

  localparam int CNT_W = $clog2(TICK_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [TICK_W-1:0] q;
  logic [PER_W-1:0] dvs;

  logic [PER_W:0]   trial;
  logic [PER_W:0]   diff;
  logic [PER_W-1:0] rem_next;

  always_comb begin
    trial    = {rem, q[TICK_W-1]};
    diff     = trial - {1'b0, dvs};
    rem_next = (trial >= {1'b0, dvs}) ? diff[PER_W-1:0] : trial[PER_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(TICK_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      q   <= {q[TICK_W-2:0], 1'b0};
      rem <= rem_next;
    end
  end

endmodule
`default_nettype wire

/* design/ptd_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptd_datapath
// Request capture, period/offset tables, tick register, remainder unit,
// pending fire slot and response register.
// ----------------------------------------------------------------------------
module ptd_datapath import ptd_pkg::*; #(
  parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [CH_W-1:0]   in_channel,
  input  logic [PER_W-1:0]  in_period,
  input  logic [TICK_W-1:0] in_tick_value,
  ptd_cfg_if.sink           cfg,
  ptd_rsp_if.source         rsp,
  input  ptd_cmd_t          ctl,
  output ptd_sts_t          sts
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int LIMIT = (NUM_CHANNELS < SCAN_LIMIT) ? NUM_CHANNELS : SCAN_LIMIT;
  localparam logic [8:0]       NUM_V   = 9'(NUM_CHANNELS);
  localparam logic [ACT_W-1:0] LIMIT_V = ACT_W'(LIMIT);

  logic [CMD_W-1:0]  req_cmd;
  logic [CH_W-1:0]   req_chan;
  logic [PER_W-1:0]  req_per;
  logic [TICK_W-1:0] req_tick;

  logic [TICK_W-1:0] last_tick;
  logic [ACT_W-1:0]  active;
  logic [ACT_W-1:0]  scan_n;
  logic [CH_W-1:0]   scan_ch;

  logic [PER_W-1:0]  per_mem [NUM_CHANNELS];
  logic [PER_W-1:0]  off_mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] vld;
  logic [PER_W-1:0]  rd_per_raw;
  logic [PER_W-1:0]  rd_off_raw;
  logic              rd_vld;
  logic [PER_W-1:0]  tbl_per;
  logic [PER_W-1:0]  tbl_off;

  logic              chan_ok;
  logic [7:0]        rd_addr8;
  logic [IDX_W-1:0]  rd_addr;
  logic [7:0]        wr_addr8;
  logic [IDX_W-1:0]  wr_addr;

  logic [TICK_W-1:0] div_dividend;
  logic [PER_W-1:0]  div_divisor;
  logic              div_done;
  logic [PER_W-1:0]  div_rem;

  logic              pend_valid;
  logic [CH_W-1:0]   pend_ch;
  logic [PER_W-1:0]  pend_per;

  logic              out_valid;
  logic              out_free;

  assign cfg.ready = 1'b1;

  always_comb begin
    chan_ok  = {5'd0, req_chan} < NUM_V;
    scan_n   = (active > LIMIT_V) ? LIMIT_V : active;
    rd_addr8 = ctl.rd_scan ? {4'd0, scan_ch} : (chan_ok ? {4'd0, req_chan} : 8'd0);
    rd_addr  = rd_addr8[IDX_W-1:0];
    wr_addr8 = {4'd0, req_chan};
    wr_addr  = wr_addr8[IDX_W-1:0];
    tbl_per  = rd_vld ? rd_per_raw : '0;
    tbl_off  = rd_vld ? rd_off_raw : '0;
    out_free = !out_valid || rsp.ready;
    div_dividend = ctl.div_scan ? (last_tick - {{(TICK_W-PER_W){1'b0}}, tbl_off})
                                : last_tick;
    div_divisor  = ctl.div_scan ? tbl_per : req_per;
  end

  always_comb begin
    sts.cmd          = cmd_t'(req_cmd);
    sts.chan_ok      = chan_ok;
    sts.per_zero     = (req_per == '0);
    sts.tbl_per_zero = (tbl_per == '0);
    sts.div_done     = div_done;
    sts.rem_zero     = (div_rem == '0);
    sts.scan_last    = (ACT_W'({1'b0, scan_ch}) + ACT_W'(1)) == scan_n;
    sts.scan_empty   = (scan_n == '0);
    sts.out_free     = out_free;
    sts.pend_valid   = pend_valid;
  end

  ptd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .rem      (div_rem)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_tick  <= '0;
      active     <= ACT_RESET;
      vld        <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg.valid) begin
        active <= cfg.active_channels;
      end
      if (ctl.store_tick) begin
        last_tick <= req_tick;
      end
      if (ctl.tbl_wr) begin
        vld[wr_addr] <= 1'b1;
      end
      if (ctl.pend_clr) begin
        pend_valid <= 1'b0;
      end else if (ctl.pend_load) begin
        pend_valid <= 1'b1;
      end
      if (ctl.out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      req_cmd  <= in_command;
      req_chan <= in_channel;
      req_per  <= in_period;
      req_tick <= in_tick_value;
    end
    if (ctl.scan_clr) begin
      scan_ch <= '0;
    end else if (ctl.scan_inc) begin
      scan_ch <= scan_ch + 1'b1;
    end
    if (ctl.pend_load) begin
      pend_ch  <= scan_ch;
      pend_per <= tbl_per;
    end
    if (ctl.out_load) begin
      rsp.current_tick <= last_tick;
      case (ctl.out_src)
        OUT_READ: begin
          rsp.kind        <= KIND_READ;
          rsp.out_channel <= req_chan;
          rsp.out_period  <= chan_ok ? tbl_per : '0;
          rsp.last        <= 1'b1;
        end
        OUT_FIRE_MID: begin
          rsp.kind        <= KIND_FIRE;
          rsp.out_channel <= pend_ch;
          rsp.out_period  <= pend_per;
          rsp.last        <= 1'b0;
        end
        default: begin
          rsp.kind        <= KIND_FIRE;
          rsp.out_channel <= pend_ch;
          rsp.out_period  <= pend_per;
          rsp.last        <= 1'b1;
        end
      endcase
    end
  end

  // tables
  always_ff @(posedge clk) begin
    if (ctl.tbl_wr) begin
      per_mem[wr_addr] <= req_per;
      off_mem[wr_addr] <= ctl.wr_zero ? '0 : div_rem;
    end
    if (ctl.tbl_rd) begin
      rd_per_raw <= per_mem[rd_addr];
      rd_off_raw <= off_mem[rd_addr];
      rd_vld     <= vld[rd_addr];
    end
  end

  assign rsp.valid = out_valid;

endmodule
`default_nettype wire

/* design/ptd_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptd_ctrl
// Sequencer for request decode, interval update, readback and the tick scan.
// ----------------------------------------------------------------------------
module ptd_ctrl import ptd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  ptd_sts_t sts,
  output ptd_cmd_t ctl
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SET_DIV,
    S_RD_OUT,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SCAN_DIV,
    S_FIRE,
    S_FLUSH
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    ctl        = '0;
    ctl.out_src = OUT_READ;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.cmd)
          CMD_TICK: begin
            ctl.store_tick = 1'b1;
            ctl.scan_clr   = 1'b1;
            state_next     = sts.scan_empty ? S_IDLE : S_SCAN_RD;
          end
          CMD_SET: begin
            if (!sts.chan_ok) begin
              state_next = S_IDLE;
            end else if (sts.per_zero) begin
              ctl.tbl_wr  = 1'b1;
              ctl.wr_zero = 1'b1;
              state_next  = S_IDLE;
            end else begin
              ctl.div_start = 1'b1;
              state_next    = S_SET_DIV;
            end
          end
          CMD_READ: begin
            ctl.tbl_rd = 1'b1;
            state_next = S_RD_OUT;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_SET_DIV: begin
        if (sts.div_done) begin
          ctl.tbl_wr = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RD_OUT: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          ctl.out_src  = OUT_READ;
          state_next   = S_IDLE;
        end
      end
      S_SCAN_RD: begin
        ctl.tbl_rd  = 1'b1;
        ctl.rd_scan = 1'b1;
        state_next  = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (sts.tbl_per_zero) begin
          ctl.scan_inc = !sts.scan_last;
          state_next   = sts.scan_last ? S_FLUSH : S_SCAN_RD;
        end else begin
          ctl.div_start = 1'b1;
          ctl.div_scan  = 1'b1;
          state_next    = S_SCAN_DIV;
        end
      end
      S_SCAN_DIV: begin
        if (sts.div_done) begin
          if (sts.rem_zero) begin
            state_next = S_FIRE;
          end else begin
            ctl.scan_inc = !sts.scan_last;
            state_next   = sts.scan_last ? S_FLUSH : S_SCAN_RD;
          end
        end
      end
      S_FIRE: begin
        if (!sts.pend_valid || sts.out_free) begin
          ctl.out_load  = sts.pend_valid;
          ctl.out_src   = OUT_FIRE_MID;
          ctl.pend_load = 1'b1;
          ctl.scan_inc  = !sts.scan_last;
          state_next    = sts.scan_last ? S_FLUSH : S_SCAN_RD;
        end
      end
      S_FLUSH: begin
        if (!sts.pend_valid) begin
          state_next = S_IDLE;
        end else if (sts.out_free) begin
          ctl.out_load = 1'b1;
          ctl.out_src  = OUT_FIRE_LAST;
          ctl.pend_clr = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

/* design/periodic_tick_dispatcher.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_tick_dispatcher
// Read interval: table read, then the response once the output is free. Set
// interval: period 0 writes a zero offset, else a 32-step serial remainder.
// Tick: each scanned channel that is enabled runs the remainder and fires
// when it is zero; a response stall can hold the scan. One request at a time.
// Reset clears the table valid bits (all entries read as zero), the stored
// tick, and sets active_channels to 16; no clearing pass.
// ----------------------------------------------------------------------------
module periodic_tick_dispatcher import ptd_pkg::*; #(
  parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
  input  logic      clk,
  input  logic      rst,
  ptd_cfg_if.sink   cfg,
  ptd_req_if.sink   req,
  ptd_rsp_if.source rsp
);

  ptd_cmd_t ctl;
  ptd_sts_t sts;
  logic     in_ready;

  assign req.ready = in_ready;

  ptd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  ptd_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .in_command    (req.command),
    .in_channel    (req.channel),
    .in_period     (req.period),
    .in_tick_value (req.tick_value),
    .cfg           (cfg),
    .rsp           (rsp),
    .ctl           (ctl),
    .sts           (sts)
  );

endmodule
`default_nettype wire
